FILE: sv/erfd_pkg.sv
// ----------------------------------------------------------------------------
// erfd_pkg
// Shared types and constants of the receive filter and connection demux.
// ----------------------------------------------------------------------------
package erfd_pkg;

    localparam int CONNECTIONS = 32;
    localparam int MCAST_SLOTS = 4;
    localparam int CONN_AW     = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
    localparam int ADDR_W      = 48;
    localparam int TYPE_W      = 16;
    localparam int TARGET_W    = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;

    typedef enum logic [1:0] {
        FUNC_RX    = 2'd0,
        FUNC_TX    = 2'd1,
        FUNC_WRITE = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ACT_ORIGINAL   = 3'd0,
        ACT_COPY       = 3'd1,
        ACT_TRACE      = 3'd2,
        ACT_TO_WIRE    = 3'd3,
        ACT_FILTERED   = 3'd4,
        ACT_DISCARDED  = 3'd5,
        ACT_RETURNED   = 3'd6,
        ACT_WRITE_DONE = 3'd7
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STATION  = 3'd0,
        CFG_PROM     = 3'd1,
        CFG_MCAST0   = 3'd2,
        CFG_MCAST1   = 3'd3,
        CFG_MCAST2   = 3'd4,
        CFG_MCAST3   = 3'd5,
        CFG_MCAST_EN = 3'd6
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_FILT,
        S_SCAN,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [TYPE_W-1:0] conn_type;
        logic              any_type;
        logic              prom;
        logic              bridge;
        logic              headers_only;
    } t_conn_entry;

    typedef struct packed {
        logic               en;
        logic [CONN_AW-1:0] addr;
        logic               valid;
        t_conn_entry        entry;
    } t_tbl_wr;

endpackage

FILE: sv/erfd_conn_table.sv
// ----------------------------------------------------------------------------
// erfd_conn_table
// Connection table: one synchronous memory for the entry payload and a row
// of valid flops that reset clears at once.
// ----------------------------------------------------------------------------
module erfd_conn_table
    import erfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_tbl_wr            i_wr,
    input  logic [CONN_AW-1:0] i_rd_addr,
    output logic               o_rd_valid,
    output t_conn_entry        o_rd_entry
);

    t_conn_entry            r_mem [CONNECTIONS];
    logic [CONNECTIONS-1:0] r_valid;
    logic                   r_rd_valid;
    t_conn_entry            r_rd_entry;
    logic                   rd_in_range;

    assign rd_in_range = int'(i_rd_addr) < CONNECTIONS;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.entry;
        end
        r_rd_entry <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= i_wr.valid;
            end
            r_rd_valid <= rd_in_range && r_valid[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_entry = r_rd_entry;

endmodule

FILE: sv/ethernet_rx_filter_demux_top.sv
// ----------------------------------------------------------------------------
// ethernet_rx_filter_demux_top
// Address filter and ethertype demultiplexer over a table of connections.
// ----------------------------------------------------------------------------
// One item at a time. A table write or an unused selector goes straight
// to the final state and answers with a single result. A frame passes the
// address checks and then, when it is scanned, every table entry in turn,
// read from the table memory one entry per cycle; a filtered loopback
// instead passes a filter state that reports it as filtered. Each item
// ends with its final result. Results appear on the output ports at most
// one per cycle with o_strobe and cannot be held off; the item's final
// result carries o_last. busy drops in the cycle that shows the final
// result, so the next start may follow at once.
// Table writes happen only while idle, so a scan never sees a table entry
// change under it.
module ethernet_rx_filter_demux_top
    import erfd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_func,
    input  logic [ADDR_W-1:0]    i_dest_addr,
    input  logic [ADDR_W-1:0]    i_src_addr,
    input  logic [TYPE_W-1:0]    i_ether_type,
    input  logic [4:0]           i_conn_index,
    input  logic                 i_conn_valid,
    input  logic [TYPE_W-1:0]    i_conn_type,
    input  logic                 i_conn_any_type,
    input  logic                 i_conn_prom,
    input  logic                 i_conn_bridge,
    input  logic                 i_conn_headers_only,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0]    i_cfg_data,
    output logic                 o_strobe,
    output logic [2:0]           o_action,
    output logic [TARGET_W-1:0]  o_target_conn,
    output logic                 o_last
);

    // Configuration registers.
    logic [ADDR_W-1:0] r_station;
    logic              r_prom;
    logic [ADDR_W-1:0] r_mcast_addr [4];
    logic [3:0]        r_mcast_en;

    // Control and item registers.
    t_state             r_state, n_state;
    t_func              r_func, n_func;
    logic [ADDR_W-1:0]  r_dest, n_dest;
    logic [ADDR_W-1:0]  r_src, n_src;
    logic [TYPE_W-1:0]  r_type, n_type;
    logic               r_tome, n_tome;
    logic               r_fromme, n_fromme;
    logic               r_multi, n_multi;
    logic [CONN_AW-1:0] r_scan_idx, n_scan_idx;
    logic [CONN_AW-1:0] r_taker, n_taker;
    logic               r_taker_found, n_taker_found;
    t_action            r_final_act, n_final_act;

    // Output registers.
    logic                r_strobe, n_strobe;
    t_action             r_action, n_action;
    logic [TARGET_W-1:0] r_target, n_target;
    logic                r_last, n_last;

    // Address checks, evaluated in the check state.
    logic accept;
    logic bcast;
    logic mcast_hit;
    logic filtered;
    logic tome_now;
    logic loopback;

    // Table interface.
    t_tbl_wr            tbl_wr;
    logic [CONN_AW-1:0] rd_addr;
    logic               rd_valid;
    t_conn_entry        rd_entry;
    logic               fromwire;
    logic               match;
    logic               scan_end;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station  <= '0;
            r_prom     <= 1'b0;
            r_mcast_en <= '0;
            for (int i = 0; i < 4; i++) begin
                r_mcast_addr[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_STATION:  r_station       <= i_cfg_data;
                CFG_PROM:     r_prom          <= i_cfg_data[0];
                CFG_MCAST0:   r_mcast_addr[0] <= i_cfg_data;
                CFG_MCAST1:   r_mcast_addr[1] <= i_cfg_data;
                CFG_MCAST2:   r_mcast_addr[2] <= i_cfg_data;
                CFG_MCAST3:   r_mcast_addr[3] <= i_cfg_data;
                CFG_MCAST_EN: r_mcast_en      <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        mcast_hit = 1'b0;
        for (int i = 0; i < MCAST_SLOTS; i++) begin
            if (r_mcast_en[i] && (r_mcast_addr[i] == r_dest)) begin
                mcast_hit = 1'b1;
            end
        end
    end

    assign bcast    = (r_dest == BCAST_ADDR);
    assign tome_now = (r_dest == r_station);
    assign filtered = r_dest[40] && !bcast && !r_prom && !mcast_hit;
    assign loopback = tome_now || bcast || r_prom;

    // The table write is taken straight from the ports at the accept edge.
    always_comb begin
        tbl_wr.en                 = accept && (t_func'(i_func) == FUNC_WRITE)
                                    && (int'(i_conn_index) < CONNECTIONS);
        tbl_wr.addr               = CONN_AW'(i_conn_index);
        tbl_wr.valid              = i_conn_valid;
        tbl_wr.entry.conn_type    = i_conn_type;
        tbl_wr.entry.any_type     = i_conn_any_type;
        tbl_wr.entry.prom         = i_conn_prom;
        tbl_wr.entry.bridge       = i_conn_bridge;
        tbl_wr.entry.headers_only = i_conn_headers_only;
    end

    // Entry 0 is read during the check; each scan cycle reads the next one.
    assign rd_addr = (r_state == S_CHECK) ? '0 : r_scan_idx + 1'b1;

    erfd_conn_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_entry (rd_entry)
    );

    assign fromwire = (r_func == FUNC_RX);
    assign scan_end = (r_scan_idx == CONN_AW'(CONNECTIONS - 1));
    assign match    = rd_valid
                      && (rd_entry.any_type || (rd_entry.conn_type == r_type))
                      && (r_tome || r_multi || rd_entry.prom)
                      && !(rd_entry.bridge && !fromwire && !r_fromme);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_func'(i_func) == FUNC_RX || t_func'(i_func) == FUNC_TX) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_FINAL;
                    end
                end
            end
            S_CHECK: begin
                if (fromwire) begin
                    n_state = filtered ? S_FINAL : S_SCAN;
                end else if (!loopback) begin
                    n_state = S_FINAL;
                end else begin
                    n_state = filtered ? S_FILT : S_SCAN;
                end
            end
            S_FILT: n_state = S_FINAL;
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and results.
    always_comb begin
        n_func        = r_func;
        n_dest        = r_dest;
        n_src         = r_src;
        n_type        = r_type;
        n_tome        = r_tome;
        n_fromme      = r_fromme;
        n_multi       = r_multi;
        n_scan_idx    = r_scan_idx;
        n_taker       = r_taker;
        n_taker_found = r_taker_found;
        n_final_act   = r_final_act;
        n_strobe      = 1'b0;
        n_action      = r_action;
        n_target      = '0;
        n_last        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func        = t_func'(i_func);
                    n_dest        = i_dest_addr;
                    n_src         = i_src_addr;
                    n_type        = i_ether_type;
                    n_taker_found = 1'b0;
                    n_final_act   = (t_func'(i_func) == FUNC_WRITE) ? ACT_WRITE_DONE
                                                                    : ACT_RETURNED;
                end
            end
            S_CHECK: begin
                n_tome     = tome_now;
                n_fromme   = (r_src == r_station);
                n_multi    = r_dest[40];
                n_scan_idx = '0;
                if (fromwire) begin
                    n_final_act = filtered ? ACT_FILTERED : ACT_DISCARDED;
                end else begin
                    n_final_act = tome_now ? ACT_DISCARDED : ACT_TO_WIRE;
                end
            end
            S_FILT: begin
                n_strobe = 1'b1;
                n_action = ACT_FILTERED;
            end
            S_SCAN: begin
                n_scan_idx = r_scan_idx + 1'b1;
                if (match) begin
                    if (rd_entry.headers_only) begin
                        n_strobe = 1'b1;
                        n_action = ACT_TRACE;
                        n_target = TARGET_W'(r_scan_idx);
                    end else if (fromwire && !r_taker_found) begin
                        // The first plain taker gets the original at the end.
                        n_taker_found = 1'b1;
                        n_taker       = r_scan_idx;
                        n_final_act   = ACT_ORIGINAL;
                    end else begin
                        n_strobe = 1'b1;
                        n_action = ACT_COPY;
                        n_target = TARGET_W'(r_scan_idx);
                    end
                end
            end
            S_FINAL: begin
                n_strobe = 1'b1;
                n_last   = 1'b1;
                n_action = r_final_act;
                if (r_final_act == ACT_ORIGINAL) begin
                    n_target = TARGET_W'(r_taker);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_strobe      <= 1'b0;
            r_last        <= 1'b0;
            r_taker_found <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_strobe      <= n_strobe;
            r_last        <= n_last;
            r_taker_found <= n_taker_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func      <= n_func;
        r_dest      <= n_dest;
        r_src       <= n_src;
        r_type      <= n_type;
        r_tome      <= n_tome;
        r_fromme    <= n_fromme;
        r_multi     <= n_multi;
        r_scan_idx  <= n_scan_idx;
        r_taker     <= n_taker;
        r_final_act <= n_final_act;
        r_action    <= n_action;
        r_target    <= n_target;
    end

    assign o_strobe      = r_strobe;
    assign o_action      = r_action;
    assign o_target_conn = r_target;
    assign o_last        = r_last;

    // An item's final result is never directly followed by another result.
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |=> !o_strobe)
        else $error("result directly after the final result of an item");

    // Accepting an item makes the block busy.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accepting an item");

    // The original delivery is always the final result of a received frame.
    a_original_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_action == ACT_ORIGINAL) |-> o_last)
        else $error("original delivery not marked last");

    // Results before the final one appear only while the item is still busy.
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("intermediate result while idle");

endmodule

FILE: dv/tb_ethernet_rx_filter_demux_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ethernet_rx_filter_demux_top
// Self-checking bench for the receive filter and connection demultiplexer.
// A driver sends frame headers and table writes from a request queue. A
// predictor keeps its own copy of the connection table and the filter
// registers and queues the deliveries that each request should produce.
// A monitor compares every result strobe with the oldest queued delivery.
// Filter settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb_ethernet_rx_filter_demux_top;
    import erfd_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int END_CYCLES  = CONNECTIONS + 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 48;
    localparam logic [3:0][TYPE_W-1:0] COMMON_TYPES = {
        16'h88CC, 16'h86DD, 16'h0806, 16'h0800
    };

    typedef struct {
        t_func               func;
        logic [ADDR_W-1:0]   dest;
        logic [ADDR_W-1:0]   src;
        logic [TYPE_W-1:0]   etype;
        logic [4:0]          idx;
        logic                valid;
        logic [TYPE_W-1:0]   ctype;
        logic                any_type;
        logic                prom;
        logic                bridge;
        logic                hdr_only;
        logic                drain_first;
        logic                quiet;
    } t_request;

    typedef struct {
        t_action             act;
        logic [TARGET_W-1:0] conn;
        logic                last;
    } t_delivery;

    logic                  i_clk;
    logic                  i_rst_n             = 1'b0;
    logic                  start               = 1'b0;
    logic                  busy;
    logic [1:0]            i_func              = '0;
    logic [ADDR_W-1:0]     i_dest_addr         = '0;
    logic [ADDR_W-1:0]     i_src_addr          = '0;
    logic [TYPE_W-1:0]     i_ether_type        = '0;
    logic [4:0]            i_conn_index        = '0;
    logic                  i_conn_valid        = 1'b0;
    logic [TYPE_W-1:0]     i_conn_type         = '0;
    logic                  i_conn_any_type     = 1'b0;
    logic                  i_conn_prom         = 1'b0;
    logic                  i_conn_bridge       = 1'b0;
    logic                  i_conn_headers_only = 1'b0;
    logic                  i_cfg_valid         = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index         = CFG_STATION;
    logic [ADDR_W-1:0]     i_cfg_data          = '0;
    logic                  o_strobe;
    logic [2:0]            o_action;
    logic [TARGET_W-1:0]   o_target_conn;
    logic                  o_last;

    // Shadow of the filter registers and the connection table.
    logic [ADDR_W-1:0]       sh_station  = '0;
    logic                    sh_prom     = 1'b0;
    logic [3:0][ADDR_W-1:0]  sh_mcast    = '0;
    logic [3:0]              sh_mcast_en = '0;
    logic                    tbl_valid [CONNECTIONS];
    t_conn_entry             conn_tbl  [CONNECTIONS];

    t_request    request_q [$];
    t_delivery   delivery_q [$];
    t_request    cur_req;
    logic        quiet_phase = 1'b0;
    logic        drain_next  = 1'b0;
    int unsigned gap_left    = 0;
    logic        gap_after_done = 1'b0;
    int unsigned stall_cycles = 0;
    int unsigned mismatches   = 0;

    ethernet_rx_filter_demux_top uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_func              (i_func),
        .i_dest_addr         (i_dest_addr),
        .i_src_addr          (i_src_addr),
        .i_ether_type        (i_ether_type),
        .i_conn_index        (i_conn_index),
        .i_conn_valid        (i_conn_valid),
        .i_conn_type         (i_conn_type),
        .i_conn_any_type     (i_conn_any_type),
        .i_conn_prom         (i_conn_prom),
        .i_conn_bridge       (i_conn_bridge),
        .i_conn_headers_only (i_conn_headers_only),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_strobe            (o_strobe),
        .o_action            (o_action),
        .o_target_conn       (o_target_conn),
        .o_last              (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic void note_delivery(t_action act, logic [TARGET_W-1:0] conn);
        t_delivery d;
        d.act  = act;
        d.conn = conn;
        d.last = 1'b0;
        delivery_q.push_back(d);
    endfunction

    function automatic void scan_frame(t_request req, logic from_wire);
        logic multi;
        logic tome;
        logic fromme;
        logic slot_hit;
        int   taker;
        multi    = req.dest[40];
        slot_hit = 1'b0;
        for (int s = 0; s < MCAST_SLOTS; s++)
            if (sh_mcast_en[s] && sh_mcast[s] == req.dest)
                slot_hit = 1'b1;
        // Group addresses other than broadcast need promiscuous mode or a slot.
        if (multi && req.dest != BCAST_ADDR && !sh_prom && !slot_hit) begin
            note_delivery(ACT_FILTERED, '0);
            return;
        end
        tome   = req.dest == sh_station;
        fromme = req.src == sh_station;
        taker  = -1;
        for (int i = 0; i < CONNECTIONS; i++) begin
            if (!tbl_valid[i])
                continue;
            if (!(conn_tbl[i].any_type || conn_tbl[i].conn_type == req.etype))
                continue;
            if (!(tome || multi || conn_tbl[i].prom))
                continue;
            if (conn_tbl[i].bridge && !from_wire && !fromme)
                continue;
            if (conn_tbl[i].headers_only)
                note_delivery(ACT_TRACE, TARGET_W'(i));
            else if (from_wire && taker < 0)
                taker = i;
            else
                note_delivery(ACT_COPY, TARGET_W'(i));
        end
        // The connection that takes the original is reported after the copies.
        if (taker >= 0)
            note_delivery(ACT_ORIGINAL, TARGET_W'(taker));
        else if (from_wire)
            note_delivery(ACT_DISCARDED, '0);
    endfunction

    function automatic void predict_delivery(t_request req);
        t_delivery tail;
        logic      self;
        self = req.dest == sh_station;
        case (req.func)
            FUNC_RX: begin
                scan_frame(req, 1'b1);
            end
            FUNC_TX: begin
                if (self || req.dest == BCAST_ADDR || sh_prom)
                    scan_frame(req, 1'b0);
                if (self)
                    note_delivery(ACT_DISCARDED, '0);
                else
                    note_delivery(ACT_TO_WIRE, '0);
            end
            FUNC_WRITE: begin
                if (req.idx < CONNECTIONS) begin
                    tbl_valid[req.idx]              = req.valid;
                    conn_tbl[req.idx].conn_type     = req.ctype;
                    conn_tbl[req.idx].any_type      = req.any_type;
                    conn_tbl[req.idx].prom          = req.prom;
                    conn_tbl[req.idx].bridge        = req.bridge;
                    conn_tbl[req.idx].headers_only  = req.hdr_only;
                end
                note_delivery(ACT_WRITE_DONE, '0);
            end
            default: begin
                note_delivery(ACT_RETURNED, '0);
            end
        endcase
        tail = delivery_q.pop_back();
        tail.last = 1'b1;
        delivery_q.push_back(tail);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [ADDR_W-1:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [ADDR_W-1:0] pick_addr();
        logic [ADDR_W-1:0] a;
        a = rand48();
        case ($urandom_range(0, 9))
            0, 1:    a = sh_station;
            2:       a = BCAST_ADDR;
            3, 4:    a = sh_mcast[$urandom_range(0, 3)];
            5:       a[40] = 1'b1;
            6, 7:    a[40] = 1'b0;
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [TYPE_W-1:0] pick_type();
        if ($urandom_range(0, 7) < 6)
            return COMMON_TYPES[$urandom_range(0, 3)];
        return 16'($urandom);
    endfunction

    // Fields that the function ignores carry random values.
    function automatic t_request blank_request(t_func func);
        t_request req;
        req.func        = func;
        req.dest        = rand48();
        req.src         = rand48();
        req.etype       = 16'($urandom);
        req.idx         = 5'($urandom);
        req.valid       = 1'($urandom);
        req.ctype       = 16'($urandom);
        req.any_type    = 1'($urandom);
        req.prom        = 1'($urandom);
        req.bridge      = 1'($urandom);
        req.hdr_only    = 1'($urandom);
        req.drain_first = drain_next;
        req.quiet       = quiet_phase;
        return req;
    endfunction

    function automatic void queue_frame(t_func func, logic [ADDR_W-1:0] dest,
                                        logic [ADDR_W-1:0] src,
                                        logic [TYPE_W-1:0] etype);
        t_request req;
        req       = blank_request(func);
        req.dest  = dest;
        req.src   = src;
        req.etype = etype;
        request_q.push_back(req);
    endfunction

    function automatic void queue_conn(logic [4:0] idx, logic valid,
                                       logic [TYPE_W-1:0] ctype, logic any_type,
                                       logic prom, logic bridge, logic hdr_only);
        t_request req;
        req          = blank_request(FUNC_WRITE);
        req.idx      = idx;
        req.valid    = valid;
        req.ctype    = ctype;
        req.any_type = any_type;
        req.prom     = prom;
        req.bridge   = bridge;
        req.hdr_only = hdr_only;
        request_q.push_back(req);
    endfunction

    task automatic write_reg(input t_cfg_reg idx, input logic [ADDR_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_STATION:  sh_station  = value;
            CFG_PROM:     sh_prom     = value[0];
            CFG_MCAST0:   sh_mcast[0] = value;
            CFG_MCAST1:   sh_mcast[1] = value;
            CFG_MCAST2:   sh_mcast[2] = value;
            CFG_MCAST3:   sh_mcast[3] = value;
            CFG_MCAST_EN: sh_mcast_en = value[3:0];
            default:      ;
        endcase
    endtask

    // Called at a rising edge with the block idle; returns at a falling edge.
    task automatic program_filter(input logic [ADDR_W-1:0] station, input logic prom,
                                  input logic [3:0][ADDR_W-1:0] mc,
                                  input logic [3:0] en);
        write_reg(CFG_STATION, station);
        write_reg(CFG_PROM, {47'($urandom), prom});
        write_reg(CFG_MCAST0, mc[0]);
        write_reg(CFG_MCAST1, mc[1]);
        write_reg(CFG_MCAST2, mc[2]);
        write_reg(CFG_MCAST3, mc[3]);
        write_reg(CFG_MCAST_EN, {44'(rand48()), en});
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Settled values are checked on the falling edge, so that a request popped
    // by the driver at the same rising edge cannot slip past.
    task automatic wait_idle();
        while (request_q.size() != 0 || start || delivery_q.size() != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
            for (int k = 0; k < CONNECTIONS; k++)
                tbl_valid[k] = 1'b0;
        end else begin
            if (start && !busy)
                predict_delivery(cur_req);
            if (!start || !busy) begin
                if (gap_left != 0) begin
                    start <= 1'b0;
                    // Some gaps only count down once the block has gone idle.
                    if (!gap_after_done || !busy)
                        gap_left <= gap_left - 1;
                end else if (request_q.size() != 0 &&
                             !(request_q[0].drain_first && delivery_q.size() != 0)) begin
                    cur_req = request_q.pop_front();
                    i_func              <= cur_req.func;
                    i_dest_addr         <= cur_req.dest;
                    i_src_addr          <= cur_req.src;
                    i_ether_type        <= cur_req.etype;
                    i_conn_index        <= cur_req.idx;
                    i_conn_valid        <= cur_req.valid;
                    i_conn_type         <= cur_req.ctype;
                    i_conn_any_type     <= cur_req.any_type;
                    i_conn_prom         <= cur_req.prom;
                    i_conn_bridge       <= cur_req.bridge;
                    i_conn_headers_only <= cur_req.hdr_only;
                    start               <= 1'b1;
                    if (!cur_req.quiet && $urandom_range(0, 2) == 0) begin
                        gap_left       <= $urandom_range(1, 4);
                        gap_after_done <= 1'($urandom);
                    end
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: a result is held for exactly one cycle, so it is sampled in the
    // middle of that cycle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_delivery want;
        if (i_rst_n && o_strobe !== 1'b0) begin
            if (delivery_q.size() == 0) begin
                $error("result with nothing pending: action %0d, target_conn %0d, last %0d",
                       o_action, o_target_conn, o_last);
                mismatches++;
            end else begin
                want = delivery_q.pop_front();
                if (o_action !== want.act) begin
                    $error("action: expected %0d, got %0d", want.act, o_action);
                    mismatches++;
                end
                if (o_target_conn !== want.conn) begin
                    $error("target_conn: expected %0d, got %0d", want.conn, o_target_conn);
                    mismatches++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("** ethernet_rx_filter_demux_top: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [3:0][ADDR_W-1:0] mc;
        logic [ADDR_W-1:0]      stn;
        logic                   prom;
        logic [3:0]             en;
        int                     pressure_at;
        int                     pick;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Unicast station, one enabled multicast slot.
        mc = {48'h0100_5E00_00FB, 48'h0100_5E00_0002, 48'h3333_0000_0001,
              48'h0100_5E00_0001};
        program_filter(48'h0200_0000_0A01, 1'b0, mc, 4'b0001);
        queue_frame(FUNC_NONE, '0, '0, '0);
        queue_conn(5'd0, 1'b1, 16'h0800, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_conn(5'd5, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b1);
        queue_conn(5'd31, 1'b1, 16'h0800, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_conn(5'd10, 1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_frame(FUNC_RX, 48'h0200_0000_0A01, 48'h0200_0000_0B02, 16'h0800);
        queue_frame(FUNC_RX, BCAST_ADDR, BCAST_ADDR, 16'h0806);
        queue_frame(FUNC_RX, 48'h0200_0000_0B02, 48'h0200_0000_0C03, 16'hFFFF);
        queue_frame(FUNC_RX, 48'h3333_0000_0001, 48'h0200_0000_0B02, 16'h0800);
        queue_frame(FUNC_RX, 48'h0100_5E00_0001, 48'h0200_0000_0B02, 16'h0800);
        queue_frame(FUNC_RX, '0, '0, '0);
        // Loopback to self from self reaches the bridge connection.
        queue_frame(FUNC_TX, 48'h0200_0000_0A01, 48'h0200_0000_0A01, 16'h0800);
        // Broadcast loopback from another source skips the bridge.
        queue_frame(FUNC_TX, BCAST_ADDR, 48'h0200_0000_0B02, 16'h0800);
        queue_frame(FUNC_TX, 48'h0200_0000_0B02, 48'h0200_0000_0A01, 16'h0800);
        queue_frame(FUNC_TX, 48'h0100_5E00_0001, 48'h0200_0000_0A01, 16'h0800);
        queue_conn(5'd0, 1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_frame(FUNC_RX, BCAST_ADDR, '0, 16'hFFFF);
        queue_conn(5'd31, 1'b1, 16'h0800, 1'b1, 1'b0, 1'b0, 1'b0);
        wait_idle();

        // The station itself is a group address: a transmit to self is filtered.
        mc = {48'h0100_5E00_00FB, 48'h0100_5E00_0002, 48'h3333_0000_0001,
              48'hFFFF_FFFF_FFFE};
        program_filter(48'h0100_5E7F_FFFA, 1'b0, mc, 4'b1110);
        queue_frame(FUNC_TX, 48'h0100_5E7F_FFFA, 48'h0100_5E7F_FFFA, 16'h0800);
        queue_frame(FUNC_RX, 48'h0100_5E7F_FFFA, 48'h0200_0000_0B02, 16'h0800);
        queue_frame(FUNC_RX, 48'h0100_5E00_00FB, 48'h0200_0000_0B02, 16'h86DD);
        queue_frame(FUNC_RX, 48'hFFFF_FFFF_FFFE, 48'h0200_0000_0B02, 16'h0800);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            if (ph == 0) begin
                stn  = BCAST_ADDR;
                prom = 1'b0;
                mc   = '0;
                en   = 4'hF;
            end else if (ph == 1) begin
                stn  = '0;
                prom = 1'b1;
                mc   = '1;
                en   = 4'h0;
            end else begin
                stn     = rand48();
                stn[40] = $urandom_range(0, 3) == 0;
                prom    = 1'($urandom);
                for (int s = 0; s < 4; s++) begin
                    mc[s]     = rand48();
                    mc[s][40] = 1'b1;
                end
                en = 4'($urandom);
            end
            program_filter(stn, prom, mc, en);
            quiet_phase = ph == PHASES - 1;
            pressure_at = $urandom_range(0, PHASE_ITEMS - 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // The last phase runs without any pause on the sending side.
                drain_next = (n == pressure_at) && !quiet_phase;
                pick = $urandom_range(0, 19);
                if (pick < 8)
                    queue_frame(FUNC_RX, pick_addr(), pick_addr(), pick_type());
                else if (pick < 15)
                    queue_frame(FUNC_TX, pick_addr(), pick_addr(), pick_type());
                else if (pick < 19)
                    queue_conn(5'($urandom), $urandom_range(0, 4) != 0, pick_type(),
                               $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                               $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
                else
                    queue_frame(FUNC_NONE, rand48(), rand48(), 16'($urandom));
            end
            drain_next = 1'b0;
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("** ethernet_rx_filter_demux_top: PASSED **");
        else
            $display("** ethernet_rx_filter_demux_top: FAILED **");
        $finish;
    end

endmodule
